// ----- hw/rtl/bus_request_packet_validator_defines.svh -----
// assertion macros for the bus request packet validator
// used by the controller and datapath files, no other dependencies
`ifndef BUS_REQUEST_PACKET_VALIDATOR_DEFINES_SVH
`define BUS_REQUEST_PACKET_VALIDATOR_DEFINES_SVH

// same-cycle implication
`define BRPV_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define BRPV_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/brpv_pkg.sv -----
// shared types, constants and a helper function of the bus request packet validator
// no dependencies
package brpv_pkg;

    localparam int PACKET_BYTES   = 64;
    localparam int MAX_PAYLOAD    = 32;
    localparam int PAY_AW         = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
    localparam int HDR_FIRST      = 4;
    localparam int RESERVED_FIRST = 19;
    localparam int PAYLOAD_OFFSET = 32;
    localparam int HDR_BYTES      = RESERVED_FIRST - HDR_FIRST;
    localparam int POS_W          = 7;
    localparam int POS_MAX        = 127;

    // header byte slots, counted from packet byte 4
    localparam int H_SEQ0  = 0;
    localparam int H_SEQ1  = 1;
    localparam int H_SEQ2  = 2;
    localparam int H_SEQ3  = 3;
    localparam int H_KIND  = 4;
    localparam int H_FLAGS = 5;
    localparam int H_TX    = 6;
    localparam int H_RX    = 7;
    localparam int H_RATE0 = 8;
    localparam int H_RATE1 = 9;
    localparam int H_RATE2 = 10;
    localparam int H_RATE3 = 11;
    localparam int H_TMO0  = 12;
    localparam int H_TMO1  = 13;
    localparam int H_ADDR  = 14;

    localparam logic [15:0] TMO_MAX      = 16'd100;
    localparam logic [32:0] LEASE_MARGIN = 33'd10;
    localparam logic [31:0] UART_RATE_MIN = 32'd300;
    localparam logic [31:0] UART_RATE_MAX = 32'd115200;
    localparam logic [31:0] I2C_RATE_MIN  = 32'd10000;
    localparam logic [31:0] I2C_RATE_MAX  = 32'd100000;
    localparam logic [31:0] SPI_RATE_MIN  = 32'd10000;
    localparam logic [31:0] SPI_RATE_MAX  = 32'd1000000;
    localparam logic [7:0]  I2C_ADDR_MIN  = 8'h08;
    localparam logic [7:0]  I2C_ADDR_MAX  = 8'h77;
    localparam logic [7:0]  SPI_FLAGS_MAX = 8'd3;

    localparam logic [19:0] PINS_UART = 20'h00003;
    localparam logic [19:0] PINS_I2C  = 20'h0000C;
    localparam logic [19:0] PINS_SPI  = 20'hF0000;

    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_UART_KIND = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_I2C_KIND  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SPI_KIND  = 2'd2;

    localparam logic [2:0] STAT_OK           = 3'd0;
    localparam logic [2:0] STAT_BAD_REQUEST  = 3'd1;
    localparam logic [2:0] STAT_REPLAY       = 3'd2;
    localparam logic [2:0] STAT_NO_LEASE     = 3'd3;
    localparam logic [2:0] STAT_PIN_CONFLICT = 3'd4;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] sequence_number;
        logic [7:0]  bus_kind;
        logic [7:0]  bus_flags;
        logic [7:0]  transmit_size;
        logic [7:0]  receive_size;
        logic [31:0] bus_rate;
        logic [15:0] timeout_value;
        logic [7:0]  device_address;
        logic [7:0]  payload_byte;
        logic        is_payload;
        logic        last_of_run;
    } t_res;

    typedef struct packed {
        logic take;
        logic eop;
        logic chk_a;
        logic chk_b;
        logic ld_hdr;
        logic rd_pay;
        logic ld_pay;
        logic clr;
    } t_dp_cmd;

    typedef struct packed {
        logic out_free;
        logic more_pay;
        logic pay_last;
    } t_dp_stat;

    function automatic logic [7:0] magic_byte(input logic [1:0] idx);
        logic [7:0] b;
        case (idx)
            2'd0:    b = 8'h4D;
            2'd1:    b = 8'h42;
            2'd2:    b = 8'h32;
            default: b = 8'h01;
        endcase
        return b;
    endfunction

endpackage

// ----- hw/rtl/brpv_req_if.sv -----
// request byte channel: valid/ready handshake with the packet byte and sideband
// no dependencies
interface brpv_req_if;
    logic        valid;
    logic        ready;
    logic [7:0]  data_byte;
    logic        end_of_packet;
    logic [31:0] last_sequence;
    logic        is_authorized;
    logic [31:0] lease_remaining;
    logic [19:0] pin_free_mask;

    modport source (output valid, data_byte, end_of_packet, last_sequence,
                    is_authorized, lease_remaining, pin_free_mask, input ready);
    modport sink   (input valid, data_byte, end_of_packet, last_sequence,
                    is_authorized, lease_remaining, pin_free_mask, output ready);
endinterface

// ----- hw/rtl/brpv_res_if.sv -----
// result channel: valid/ready handshake with header and payload result fields
// no dependencies
interface brpv_res_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [31:0] sequence_number;
    logic [7:0]  bus_kind;
    logic [7:0]  bus_flags;
    logic [7:0]  transmit_size;
    logic [7:0]  receive_size;
    logic [31:0] bus_rate;
    logic [15:0] timeout_value;
    logic [7:0]  device_address;
    logic [7:0]  payload_byte;
    logic        is_payload;
    logic        last_of_run;

    modport source (output valid, status, sequence_number, bus_kind, bus_flags,
                    transmit_size, receive_size, bus_rate, timeout_value,
                    device_address, payload_byte, is_payload, last_of_run,
                    input ready);
    modport sink   (input valid, status, sequence_number, bus_kind, bus_flags,
                    transmit_size, receive_size, bus_rate, timeout_value,
                    device_address, payload_byte, is_payload, last_of_run,
                    output ready);
endinterface

// ----- hw/rtl/brpv_datapath.sv -----
// datapath: byte intake, header capture, payload memory, checks and result register
// depends on brpv_pkg and bus_request_packet_validator_defines.svh
`include "bus_request_packet_validator_defines.svh"

module brpv_datapath import brpv_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_dp_cmd              i_cmd,
    output t_dp_stat             o_stat,
    input  logic [7:0]           i_data_byte,
    input  logic [31:0]          i_last_sequence,
    input  logic                 i_is_authorized,
    input  logic [31:0]          i_lease_remaining,
    input  logic [19:0]          i_pin_free_mask,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [7:0]           i_cfg_wdata,
    output t_res                 o_res,
    output logic                 o_res_valid,
    input  logic                 i_res_ready
);

    logic [7:0]        r_uart_kind, r_i2c_kind, r_spi_kind;
    logic [POS_W-1:0]  r_pos;
    logic              r_magic_ok;
    logic              r_padding_ok;
    logic [7:0]        r_hdr [HDR_BYTES];
    logic [7:0]        r_mem [MAX_PAYLOAD];
    logic [7:0]        r_rd_data;
    logic [PAY_AW-1:0] r_pay_idx;

    logic [31:0] r_last_seq;
    logic        r_auth;
    logic [31:0] r_lease;
    logic [19:0] r_pins;

    logic       r_frame_bad, r_replay, r_limit_bad;
    logic [3:0] r_kind_sel;
    logic [2:0] r_status;

    t_res r_out;
    logic r_out_vld;

    logic [31:0]      seq, rate, diff;
    logic [15:0]      tmo;
    logic [7:0]       kind, flags, tx, rx, addr;
    logic [POS_W-1:0] hdr_off, pay_off;
    logic             rule_bad, lease_bad, pin_bad;
    logic [19:0]      pin_need;
    logic [2:0]       n_status;
    logic             pay_last;
    logic             take_hit;

    assign seq  = {r_hdr[H_SEQ3], r_hdr[H_SEQ2], r_hdr[H_SEQ1], r_hdr[H_SEQ0]};
    assign kind = r_hdr[H_KIND];
    assign flags = r_hdr[H_FLAGS];
    assign tx   = r_hdr[H_TX];
    assign rx   = r_hdr[H_RX];
    assign rate = {r_hdr[H_RATE3], r_hdr[H_RATE2], r_hdr[H_RATE1], r_hdr[H_RATE0]};
    assign tmo  = {r_hdr[H_TMO1], r_hdr[H_TMO0]};
    assign addr = r_hdr[H_ADDR];
    assign diff = seq - r_last_seq;

    assign hdr_off  = r_pos - POS_W'(HDR_FIRST);
    assign pay_off  = r_pos - POS_W'(PAYLOAD_OFFSET);
    assign take_hit = i_cmd.take && (r_pos < POS_W'(PACKET_BYTES));
    assign pay_last = ((8'(r_pay_idx) + 8'd1) == tx);

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_uart_kind <= 8'd0;
            r_i2c_kind  <= 8'd1;
            r_spi_kind  <= 8'd2;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_UART_KIND: r_uart_kind <= i_cfg_wdata;
                CFG_I2C_KIND:  r_i2c_kind  <= i_cfg_wdata;
                CFG_SPI_KIND:  r_spi_kind  <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // packet control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clr) begin
            r_pos        <= '0;
            r_magic_ok   <= 1'b1;
            r_padding_ok <= 1'b1;
        end else if (i_cmd.take) begin
            if (r_pos < POS_W'(POS_MAX)) begin
                r_pos <= r_pos + POS_W'(1);
            end
            if (take_hit) begin
                if (r_pos < POS_W'(HDR_FIRST)) begin
                    if (i_data_byte != magic_byte(r_pos[1:0])) begin
                        r_magic_ok <= 1'b0;
                    end
                end else if (r_pos >= POS_W'(RESERVED_FIRST)) begin
                    if (r_pos < POS_W'(PAYLOAD_OFFSET)) begin
                        if (i_data_byte != 8'd0) begin
                            r_padding_ok <= 1'b0;
                        end
                    end else if ((8'(pay_off) >= tx) && (i_data_byte != 8'd0)) begin
                        r_padding_ok <= 1'b0;
                    end
                end
            end
        end
    end

    // header bytes and payload memory
    always_ff @(posedge i_clk) begin
        if (take_hit && (r_pos >= POS_W'(HDR_FIRST)) && (r_pos < POS_W'(RESERVED_FIRST))) begin
            r_hdr[hdr_off[3:0]] <= i_data_byte;
        end
        if (take_hit && (r_pos >= POS_W'(PAYLOAD_OFFSET))
                && (pay_off < POS_W'(MAX_PAYLOAD))) begin
            r_mem[pay_off[PAY_AW-1:0]] <= i_data_byte;
        end
        if (i_cmd.rd_pay) begin
            r_rd_data <= r_mem[r_pay_idx];
        end
    end

    // sideband sampled on the end byte
    always_ff @(posedge i_clk) begin
        if (i_cmd.eop) begin
            r_last_seq <= i_last_sequence;
            r_auth     <= i_is_authorized;
            r_lease    <= i_lease_remaining;
            r_pins     <= i_pin_free_mask;
        end
    end

    // first check stage: frame, replay, limits, kind select
    always_ff @(posedge i_clk) begin
        if (i_cmd.chk_a) begin
            r_frame_bad <= (r_pos != POS_W'(PACKET_BYTES)) || !r_magic_ok;
            r_replay    <= (seq == 32'd0) || (diff == 32'd0) || diff[31];
            r_limit_bad <= (tmo == 16'd0) || (tmo > TMO_MAX)
                        || (tx > 8'(MAX_PAYLOAD)) || (rx > 8'(MAX_PAYLOAD))
                        || ((tx == 8'd0) && (rx == 8'd0)) || !r_padding_ok;
            if (kind == r_uart_kind) begin
                r_kind_sel <= 4'b0001;
            end else if (kind == r_i2c_kind) begin
                r_kind_sel <= 4'b0010;
            end else if (kind == r_spi_kind) begin
                r_kind_sel <= 4'b0100;
            end else begin
                r_kind_sel <= 4'b1000;
            end
        end
    end

    // second check stage: kind rules, lease, pins
    always_comb begin
        rule_bad = 1'b1;
        pin_need = '0;
        case (r_kind_sel)
            4'b0001: begin
                rule_bad = (flags != 8'd0) || (addr != 8'd0)
                        || (rate < UART_RATE_MIN) || (rate > UART_RATE_MAX);
                pin_need = PINS_UART;
            end
            4'b0010: begin
                rule_bad = (flags != 8'd0) || (addr < I2C_ADDR_MIN) || (addr > I2C_ADDR_MAX)
                        || (rate < I2C_RATE_MIN) || (rate > I2C_RATE_MAX);
                pin_need = PINS_I2C;
            end
            4'b0100: begin
                rule_bad = (flags > SPI_FLAGS_MAX) || (addr != 8'd0)
                        || (rate < SPI_RATE_MIN) || (rate > SPI_RATE_MAX)
                        || ((tx != 8'd0) && (rx != 8'd0) && (tx != rx));
                pin_need = PINS_SPI;
            end
            default: begin
                rule_bad = 1'b1;
                pin_need = '0;
            end
        endcase
        lease_bad = !r_auth || ({1'b0, r_lease} < (33'(tmo) + LEASE_MARGIN));
        pin_bad   = ((r_pins & pin_need) != pin_need);
        if (r_frame_bad) begin
            n_status = STAT_BAD_REQUEST;
        end else if (r_replay) begin
            n_status = STAT_REPLAY;
        end else if (r_limit_bad || rule_bad) begin
            n_status = STAT_BAD_REQUEST;
        end else if (lease_bad) begin
            n_status = STAT_NO_LEASE;
        end else if (pin_bad) begin
            n_status = STAT_PIN_CONFLICT;
        end else begin
            n_status = STAT_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.chk_b) begin
            r_status <= n_status;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (i_cmd.ld_hdr || i_cmd.ld_pay) begin
            r_out_vld <= 1'b1;
        end else if (i_res_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.ld_hdr) begin
            r_pay_idx <= '0;
            r_out     <= '0;
            r_out.status      <= r_status;
            r_out.last_of_run <= 1'b1;
            if (!r_frame_bad) begin
                r_out.sequence_number <= seq;
                r_out.bus_kind        <= kind;
                r_out.bus_flags       <= flags;
                r_out.transmit_size   <= tx;
                r_out.receive_size    <= rx;
                r_out.bus_rate        <= rate;
                r_out.timeout_value   <= tmo;
                r_out.device_address  <= addr;
                r_out.last_of_run     <= (r_status != STAT_OK) || (tx == 8'd0);
            end
        end else if (i_cmd.ld_pay) begin
            r_pay_idx          <= r_pay_idx + PAY_AW'(1);
            r_out              <= '0;
            r_out.payload_byte <= r_rd_data;
            r_out.is_payload   <= 1'b1;
            r_out.last_of_run  <= pay_last;
        end
    end

    assign o_res       = r_out;
    assign o_res_valid = r_out_vld;

    assign o_stat.out_free = !r_out_vld || i_res_ready;
    assign o_stat.more_pay = (r_status == STAT_OK) && (tx != 8'd0);
    assign o_stat.pay_last = pay_last;

    `BRPV_ASSERT_NOW(a_no_overwrite, i_clk, i_rst_n, (i_cmd.ld_hdr || i_cmd.ld_pay),
        (!r_out_vld || i_res_ready), "result register overwritten before taken")
    `BRPV_ASSERT_NOW(a_payload_only_ok, i_clk, i_rst_n, (i_cmd.ld_pay),
        (r_status == STAT_OK), "payload result for a failed request")

endmodule

// ----- hw/rtl/brpv_controller.sv -----
// controller: sequences byte intake, the check states ST_CHK_A and ST_CHK_B and result emission
// depends on brpv_pkg and bus_request_packet_validator_defines.svh
`include "bus_request_packet_validator_defines.svh"

module brpv_controller import brpv_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    input  logic     i_eop,
    output logic     o_ready,
    output t_dp_cmd  o_cmd,
    input  t_dp_stat i_stat
);

    typedef enum logic [5:0] {
        ST_BYTE   = 6'b000001,
        ST_CHK_A  = 6'b000010,
        ST_CHK_B  = 6'b000100,
        ST_HDR    = 6'b001000,
        ST_PAY_RD = 6'b010000,
        ST_PAY    = 6'b100000
    } t_state;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_BYTE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_ready = 1'b0;
        case (r_state)
            ST_BYTE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_cmd.take = 1'b1;
                    if (i_eop) begin
                        o_cmd.eop = 1'b1;
                        n_state   = ST_CHK_A;
                    end
                end
            end
            ST_CHK_A: begin
                o_cmd.chk_a = 1'b1;
                n_state     = ST_CHK_B;
            end
            ST_CHK_B: begin
                o_cmd.chk_b = 1'b1;
                n_state     = ST_HDR;
            end
            ST_HDR: begin
                if (i_stat.out_free) begin
                    o_cmd.ld_hdr = 1'b1;
                    if (i_stat.more_pay) begin
                        n_state = ST_PAY_RD;
                    end else begin
                        o_cmd.clr = 1'b1;
                        n_state   = ST_BYTE;
                    end
                end
            end
            ST_PAY_RD: begin
                o_cmd.rd_pay = 1'b1;
                n_state      = ST_PAY;
            end
            ST_PAY: begin
                if (i_stat.out_free) begin
                    o_cmd.ld_pay = 1'b1;
                    if (i_stat.pay_last) begin
                        o_cmd.clr = 1'b1;
                        n_state   = ST_BYTE;
                    end else begin
                        n_state = ST_PAY_RD;
                    end
                end
            end
            default: begin
                n_state = ST_BYTE;
            end
        endcase
    end

    `BRPV_ASSERT_NEXT(a_eop_starts_check, i_clk, i_rst_n, (i_valid && o_ready && i_eop),
        (r_state == ST_CHK_A && !o_ready), "end byte did not start the checks")

endmodule

// ----- hw/rtl/bus_request_packet_validator.sv -----
// top level of the bus request packet validator: controller plus datapath
// depends on brpv_pkg, brpv_req_if, brpv_res_if, brpv_controller, brpv_datapath
//
//   channel   dir   handshake                 carries
//   i_req     in    valid/ready (sink)        packet byte, end mark, sideband
//   o_res     out   valid/ready (source)      header result or payload byte
//   i_cfg_*   in    write enable, no wait     kind code registers 0..2
//
// bytes are taken one per cycle until the end byte; the check states ST_CHK_A and
// ST_CHK_B follow, then one header result and, for an OK status, a payload memory read
// and a result per transmit payload byte; results wait while the result register is full
// synchronous active-low reset, no clearing pass; payload memory is not reset
// the result register lets the next packet's bytes in while the last result waits

module bus_request_packet_validator import brpv_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    brpv_req_if.sink             i_req,
    brpv_res_if.source           o_res,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [7:0]           i_cfg_wdata
);

    t_dp_cmd  cmd;
    t_dp_stat stat;
    t_res     res;
    logic     res_valid;

    brpv_controller u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_req.valid),
        .i_eop   (i_req.end_of_packet),
        .o_ready (i_req.ready),
        .o_cmd   (cmd),
        .i_stat  (stat)
    );

    brpv_datapath u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .o_stat            (stat),
        .i_data_byte       (i_req.data_byte),
        .i_last_sequence   (i_req.last_sequence),
        .i_is_authorized   (i_req.is_authorized),
        .i_lease_remaining (i_req.lease_remaining),
        .i_pin_free_mask   (i_req.pin_free_mask),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_idx         (i_cfg_idx),
        .i_cfg_wdata       (i_cfg_wdata),
        .o_res             (res),
        .o_res_valid       (res_valid),
        .i_res_ready       (o_res.ready)
    );

    assign o_res.valid           = res_valid;
    assign o_res.status          = res.status;
    assign o_res.sequence_number = res.sequence_number;
    assign o_res.bus_kind        = res.bus_kind;
    assign o_res.bus_flags       = res.bus_flags;
    assign o_res.transmit_size   = res.transmit_size;
    assign o_res.receive_size    = res.receive_size;
    assign o_res.bus_rate        = res.bus_rate;
    assign o_res.timeout_value   = res.timeout_value;
    assign o_res.device_address  = res.device_address;
    assign o_res.payload_byte    = res.payload_byte;
    assign o_res.is_payload      = res.is_payload;
    assign o_res.last_of_run     = res.last_of_run;

endmodule
